// ===== design/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion helpers for the calendar decode RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// prop must hold at every edge outside reset
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// cond must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif

`endif

// ===== design/s2cd_pkg.sv =====
// ---------------------------------------------------------------------------
// s2cd_pkg
// Constants, types and month-length function for the seconds-to-date decoder.
// ---------------------------------------------------------------------------
package s2cd_pkg;

    localparam int unsigned SECS_PER_DAY = 86400;
    localparam int unsigned SECS_PER_MIN = 60;
    localparam int unsigned DAYS_COMMON  = 365;
    localparam int unsigned DAYS_LEAP    = 366;
    localparam int unsigned FEB_OFFSET   = 337;
    localparam int unsigned YEAR_LIMIT   = 150;
    localparam int unsigned SHORT_MONTH  = 30;
    localparam int unsigned MONTH_JAN    = 1;
    localparam int unsigned MONTH_FEB    = 2;
    localparam int unsigned MONTH_DEC    = 12;

    localparam int unsigned DVD_W  = 32;   // dividend register
    localparam int unsigned REM_W  = 17;   // remainder, below 86400
    localparam int unsigned CNT_W  = 6;    // bit counter, up to 32
    localparam int unsigned DAYS_W = 16;   // whole days, below 49711
    localparam int unsigned TOD_W  = 17;   // second of day
    localparam int unsigned MOD_W  = 11;   // minute of day

    typedef struct packed {
        logic              start;
        logic [DVD_W-1:0]  dividend;   // MSB aligned
        logic [REM_W-1:0]  divisor;
        logic [CNT_W-1:0]  nbits;
    } div_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

    // days in a month; feb follows the leap flag, others the parity rule
    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        if (m == 4'(MONTH_FEB)) begin
            len = leap ? 5'(DAYS_LEAP - FEB_OFFSET) : 5'(DAYS_COMMON - FEB_OFFSET);
        end else begin
            len = 5'(SHORT_MONTH) + {4'b0, m[0] ^ m[3]};
        end
        return len;
    endfunction

endpackage

// ===== design/seconds_to_calendar_date_unit.sv =====
// ---------------------------------------------------------------------------
// seconds_to_calendar_date_unit
// Decodes seconds since the epoch into time of day and calendar date.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel s_*: one 32-bit seconds count per word (s_valid/s_ready).
//   Output channel m_*: second, minute, hour, day, month and year offset.
//   One word is in flight at a time. The count is split by a bit-serial
//   divider: 32 shifts for whole days, 17 for minutes, 11 for hours.
//   A serial walker then removes one year per cycle (up to 136 steps)
//   and one month per cycle (up to 11 steps); the divider and the year
//   walk take most of the decode time. s_ready rises in the same cycle
//   as m_valid.
//   A result waits in the output register while the receiver stalls; the
//   next word may then be taken and decoded, and it is held back until the
//   register frees.
//   Reset (aresetn low, synchronous) drops m_valid and returns to idle.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module seconds_to_calendar_date_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_seconds_count,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [5:0]  m_second_of_minute,
    output logic [5:0]  m_minute_of_hour,
    output logic [4:0]  m_hour_of_day,
    output logic [4:0]  m_day_of_month,
    output logic [3:0]  m_month_of_year,
    output logic [7:0]  m_year_offset
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_DIV_DAY, ST_DIV_TOD, ST_DIV_MOD, ST_WALK, ST_FINISH
    } state_t;

    state_t                  state_reg;
    s2cd_pkg::div_req_t      div_req_reg;
    s2cd_pkg::unit_stat_t    div_stat;
    logic [s2cd_pkg::DVD_W-1:0] div_quot;
    logic [s2cd_pkg::REM_W-1:0] div_rem;
    logic                    walk_start_reg;
    logic [s2cd_pkg::DAYS_W-1:0] days_reg;
    s2cd_pkg::unit_stat_t    walk_stat;
    logic [4:0]              walk_day;
    logic [3:0]              walk_month;
    logic [7:0]              walk_year;
    logic [5:0]              sec_reg, min_reg;
    logic [4:0]              hour_reg;
    logic                    m_valid_reg;
    logic [5:0]              m_sec_reg, m_min_reg;
    logic [4:0]              m_hour_reg, m_day_reg;
    logic [3:0]              m_month_reg;
    logic [7:0]              m_year_reg;
    logic                    div_phase;
    logic                    walk_phase;
    logic                    units_busy;
    logic                    date_ok;

    s2cd_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req       (div_req_reg),
        .stat      (div_stat),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    s2cd_walk u_walk (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .start         (walk_start_reg),
        .days          (days_reg),
        .stat          (walk_stat),
        .day_of_month  (walk_day),
        .month_of_year (walk_month),
        .year_offset   (walk_year)
    );

    assign s_ready = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            div_req_reg.start <= 1'b0;
            walk_start_reg    <= 1'b0;
            m_valid_reg       <= 1'b0;
        end else begin
            // one-cycle start pulses for the serial units
            div_req_reg.start <= ((state_reg == ST_IDLE) && s_valid) ||
                                 (((state_reg == ST_DIV_DAY) || (state_reg == ST_DIV_TOD)) &&
                                  div_stat.done);
            walk_start_reg    <= (state_reg == ST_DIV_MOD) && div_stat.done;
            // ST_FINISH only loads when the output register is free
            m_valid_reg       <= (state_reg == ST_FINISH && (!m_valid_reg || m_ready)) ||
                                 (m_valid_reg && !m_ready);
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        div_req_reg.dividend <= s_seconds_count;
                        div_req_reg.divisor  <= s2cd_pkg::REM_W'(s2cd_pkg::SECS_PER_DAY);
                        div_req_reg.nbits    <= s2cd_pkg::CNT_W'(s2cd_pkg::DVD_W);
                        state_reg            <= ST_DIV_DAY;
                    end
                end
                ST_DIV_DAY: begin
                    if (div_stat.done) begin
                        days_reg             <= div_quot[s2cd_pkg::DAYS_W-1:0];
                        div_req_reg.dividend <= {div_rem[s2cd_pkg::TOD_W-1:0],
                                                 (s2cd_pkg::DVD_W-s2cd_pkg::TOD_W)'(0)};
                        div_req_reg.divisor  <= s2cd_pkg::REM_W'(s2cd_pkg::SECS_PER_MIN);
                        div_req_reg.nbits    <= s2cd_pkg::CNT_W'(s2cd_pkg::TOD_W);
                        state_reg            <= ST_DIV_TOD;
                    end
                end
                ST_DIV_TOD: begin
                    if (div_stat.done) begin
                        sec_reg              <= div_rem[5:0];
                        div_req_reg.dividend <= {div_quot[s2cd_pkg::MOD_W-1:0],
                                                 (s2cd_pkg::DVD_W-s2cd_pkg::MOD_W)'(0)};
                        div_req_reg.divisor  <= s2cd_pkg::REM_W'(s2cd_pkg::SECS_PER_MIN);
                        div_req_reg.nbits    <= s2cd_pkg::CNT_W'(s2cd_pkg::MOD_W);
                        state_reg            <= ST_DIV_MOD;
                    end
                end
                ST_DIV_MOD: begin
                    if (div_stat.done) begin
                        min_reg        <= div_rem[5:0];
                        hour_reg       <= div_quot[4:0];
                        state_reg      <= ST_WALK;
                    end
                end
                ST_WALK: begin
                    if (walk_stat.done) begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    // wait for the output register to free up
                    if (!m_valid_reg || m_ready) begin
                        m_sec_reg   <= sec_reg;
                        m_min_reg   <= min_reg;
                        m_hour_reg  <= hour_reg;
                        m_day_reg   <= walk_day;
                        m_month_reg <= walk_month;
                        m_year_reg  <= walk_year;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_second_of_minute = m_sec_reg;
    assign m_minute_of_hour   = m_min_reg;
    assign m_hour_of_day      = m_hour_reg;
    assign m_day_of_month     = m_day_reg;
    assign m_month_of_year    = m_month_reg;
    assign m_year_offset      = m_year_reg;

    assign div_phase  = state_reg inside {ST_DIV_DAY, ST_DIV_TOD, ST_DIV_MOD};
    assign walk_phase = (state_reg == ST_WALK);
    assign units_busy = div_stat.busy || walk_stat.busy;
    assign date_ok    = (m_month_of_year inside {[4'd1:4'd12]}) && (m_day_of_month != 5'd0);

    `ASSERT_CLK(a_div_done_in_div, aclk, aresetn, div_stat.done |-> div_phase, "div done off phase")
    `ASSERT_CLK(a_walk_done_in_walk, aclk, aresetn, walk_stat.done |-> walk_phase, "walk off phase")
    `ASSERT_NEVER(a_idle_units_busy, aclk, aresetn, s_ready && units_busy, "unit busy while idle")
    `ASSERT_CLK(a_date_range, aclk, aresetn, m_valid |-> date_ok, "decoded date out of range")

endmodule

// ===== design/s2cd_div.sv =====
// ---------------------------------------------------------------------------
// s2cd_div
// Bit-serial restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module s2cd_div (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  s2cd_pkg::div_req_t             req,
    output s2cd_pkg::unit_stat_t           stat,
    output logic [s2cd_pkg::DVD_W-1:0]     quotient,
    output logic [s2cd_pkg::REM_W-1:0]     remainder
);

    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [s2cd_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic [s2cd_pkg::DVD_W-1:0]  dvd_reg, dvd_next;
    logic [s2cd_pkg::REM_W-1:0]  rem_reg, rem_next;
    logic [s2cd_pkg::REM_W-1:0]  dsr_reg, dsr_next;
    logic [s2cd_pkg::REM_W:0]    trial;
    logic [s2cd_pkg::REM_W:0]    diff;
    logic                        ge;

    assign trial = {rem_reg, dvd_reg[s2cd_pkg::DVD_W-1]};
    assign ge    = (trial >= {1'b0, dsr_reg});
    assign diff  = trial - {1'b0, dsr_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = req.nbits;
            dvd_next  = req.dividend;
            rem_next  = '0;
            dsr_next  = req.divisor;
        end else if (busy_reg) begin
            // quotient bits enter at the bottom as dividend bits leave the top
            dvd_next = {dvd_reg[s2cd_pkg::DVD_W-2:0], ge};
            rem_next = ge ? diff[s2cd_pkg::REM_W-1:0] : trial[s2cd_pkg::REM_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == s2cd_pkg::CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = dvd_reg;
    assign remainder = rem_reg;

endmodule

// ===== design/s2cd_walk.sv =====
// ---------------------------------------------------------------------------
// s2cd_walk
// Serial year then month walk over a whole-day count.
// ---------------------------------------------------------------------------
module s2cd_walk (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [s2cd_pkg::DAYS_W-1:0]   days,
    output s2cd_pkg::unit_stat_t          stat,
    output logic [4:0]                    day_of_month,
    output logic [3:0]                    month_of_year,
    output logic [7:0]                    year_offset
);

    typedef enum logic [1:0] {W_IDLE, W_YEAR, W_MONTH} wstate_t;

    wstate_t                      state_reg, state_next;
    logic                         done_reg, done_next;
    logic [s2cd_pkg::DAYS_W-1:0]  days_reg, days_next;
    logic [7:0]                   year_reg, year_next;
    logic [3:0]                   month_reg, month_next;
    logic                         leap;
    logic [8:0]                   ylen;
    logic [4:0]                   mlen;

    assign leap = (year_reg[1:0] == 2'b00);
    assign ylen = leap ? 9'(s2cd_pkg::DAYS_LEAP) : 9'(s2cd_pkg::DAYS_COMMON);
    assign mlen = s2cd_pkg::month_len(month_reg, leap);

    always_comb begin
        state_next = state_reg;
        done_next  = 1'b0;
        days_next  = days_reg;
        year_next  = year_reg;
        month_next = month_reg;
        case (state_reg)
            W_IDLE: begin
                if (start) begin
                    days_next  = days;
                    year_next  = '0;
                    state_next = W_YEAR;
                end
            end
            W_YEAR: begin
                if (year_reg < 8'(s2cd_pkg::YEAR_LIMIT) && days_reg >= {7'b0, ylen}) begin
                    days_next = days_reg - {7'b0, ylen};
                    year_next = year_reg + 1'b1;
                end else begin
                    month_next = 4'(s2cd_pkg::MONTH_JAN);
                    state_next = W_MONTH;
                end
            end
            W_MONTH: begin
                if (month_reg < 4'(s2cd_pkg::MONTH_DEC) && days_reg >= {11'b0, mlen}) begin
                    days_next  = days_reg - {11'b0, mlen};
                    month_next = month_reg + 1'b1;
                end else begin
                    done_next  = 1'b1;
                    state_next = W_IDLE;
                end
            end
            default: state_next = W_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= W_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
        days_reg  <= days_next;
        year_reg  <= year_next;
        month_reg <= month_next;
    end

    assign stat.busy     = (state_reg != W_IDLE);
    assign stat.done     = done_reg;
    assign day_of_month  = days_reg[4:0] + 5'd1;
    assign month_of_year = month_reg;
    assign year_offset   = year_reg;

endmodule
